@@ design/asrf_pkg.sv @@
// shared types and constants of the audio slip ring framer
`timescale 1ns / 1ps
`default_nettype none

package asrf_pkg;

  // field widths fixed by the interface
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FILL_W     = 13;
  localparam int RATE_W     = 17;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 12;
  localparam int START_W    = 12;
  localparam int SLIP_W     = 2;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic signed [SLIP_W-1:0] slip_t;

  // configuration register indexes
  localparam cfg_idx_t REG_RING_LEN  = 2'd0;
  localparam cfg_idx_t REG_FRAME_LEN = 2'd1;

  // register reset values
  localparam cfg_data_t RING_LEN_RST  = 13'd4096;
  localparam cfg_data_t FRAME_LEN_RST = 13'd1024;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // slip codes
  localparam slip_t SLIP_NONE = 2'sb00;
  localparam slip_t SLIP_DUP  = 2'sb01;
  localparam slip_t SLIP_DROP = 2'sb11;

endpackage

`default_nettype wire

@@ design/asrf_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module asrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/audio_slip_ring_framer_core.sv @@
// top level of the audio slip ring framer: ring store, slip control, framing
//
// usage
//   input channel (in_valid / in_stall): one beat is either a push of one
//   sample (in_cmd = push) or a read of a stored sample (in_cmd = read).
//   a push with in_rate_load set opens a chunk: the adjust rate is loaded,
//   the slip counter restarts at one and the fill is recomputed from the
//   pointers. a negative rate drops a sample every |rate| pushes, a positive
//   rate stores a sample twice every rate pushes.
//   result channel (out_valid / out_stall): exactly one beat per input beat,
//   in order, carrying frame_ready / frame_start, slip and read_data.
//   config channel (cfg_valid / cfg_ready): ring_len at index 0, frame_len
//   at index 1, always ready, to be written while the block is idle.
// throughput
//   a result passes through the ram read stage and the output register. one
//   beat per cycle is taken while the result side drains. a duplicating push
//   holds off the next beat while the second ram write is done. a frame
//   advance from a read pointer left beyond a shrunken ring runs a bit-serial
//   remainder and holds off input until the remainder finishes.
// reset
//   synchronous, active low: pointers, fill, rate and counter clear, ring_len
//   goes to 4096 and frame_len to 1024. the sample ram is not cleared.
// stall
//   a stalled result holds in the output register; one more beat can sit in
//   the ram read stage, then in_stall rises until the result side moves.
`timescale 1ns / 1ps
`default_nettype none

module audio_slip_ring_framer_core #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int RING_DEPTH   = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [SAMPLE_WIDTH-1:0]       in_sample,
  input  logic                          in_rate_load,
  input  logic signed [asrf_pkg::RATE_W-1:0] in_adjust_rate,
  input  logic [asrf_pkg::IDX_W-1:0]    in_read_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_ready,
  output logic [asrf_pkg::START_W-1:0]  out_frame_start,
  output logic signed [asrf_pkg::SLIP_W-1:0] out_slip,
  output logic [SAMPLE_WIDTH-1:0]       out_read_data,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [asrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asrf_pkg::CFG_DATA_W-1:0] cfg_data
);

  // ram address width and working width for lengths
  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam int KW = $clog2(LW + 1);

  // ---------------------------------------------------------------- state
  asrf_pkg::cfg_data_t ring_len_r, frame_len_r;
  logic [AW-1:0]       wp_r, rp_r;
  asrf_pkg::fill_t     fill_r;
  asrf_pkg::rate_t     rate_r;
  asrf_pkg::cnt_t      cnt_r;

  // pending second write of a duplicated sample
  logic                    dup_pend_r;
  logic [AW-1:0]           dup_addr_r;
  logic [SAMPLE_WIDTH-1:0] dup_data_r;

  // bit-serial remainder for the read pointer advance
  logic          mod_busy_r;
  logic [LW:0]   mod_rem_r;
  logic [LW-1:0] mod_div_r;
  logic [KW-1:0] mod_k_r;

  // ram read stage
  logic                  s1_v_r;
  logic                  s1_read_r;
  logic                  s1_idx_ok_r;
  logic                  s1_frame_r;
  logic [asrf_pkg::START_W-1:0] s1_start_r;
  asrf_pkg::slip_t       s1_slip_r;

  // output register
  logic                  out_v_r;
  logic                  out_frame_r;
  logic [asrf_pkg::START_W-1:0] out_start_r;
  asrf_pkg::slip_t       out_slip_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  // ram ports
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata, ram_rdata;

  // ---------------------------------------------------------------- handshakes
  logic in_acc, push_acc, read_acc, s1_adv;

  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = (s1_v_r && !s1_adv) || dup_pend_r || mod_busy_r;
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && (in_cmd == asrf_pkg::CMD_PUSH);
  assign read_acc = in_acc && (in_cmd == asrf_pkg::CMD_READ);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- push datapath
  logic [LW-1:0] rl_x, fl_x, len_w, flen_w;
  logic [LW-1:0] wp_x, rp_x, wp1_x, wp2_x, idx_x;
  logic [AW-1:0] wp1, wp2;
  logic          idx_ok;

  asrf_pkg::rate_t rate_eff;
  logic [asrf_pkg::RATE_W-1:0] rate_neg;
  asrf_pkg::cnt_t  cnt_base, cnt_dec, cnt_new, mag;
  logic            neg, slip_ev, is_drop, is_dup;

  asrf_pkg::fill_t fill_base, fill_st, fill_new;
  logic [LW-1:0]   fill_rc;
  logic            frame_hit;

  logic [LW:0]   sum_x, len_xx, diff_x;
  logic [AW-1:0] rp_fast;
  logic          slow_mod;

  asrf_pkg::slip_t slip_code;

  always_comb begin
    // effective ring and frame lengths
    rl_x = LW'(ring_len_r);
    fl_x = LW'(frame_len_r);
    if (ring_len_r == '0) begin
      len_w = LW'(1);
    end else if (rl_x > LW'(RING_DEPTH)) begin
      len_w = LW'(RING_DEPTH);
    end else begin
      len_w = rl_x;
    end
    if (frame_len_r == '0) begin
      flen_w = LW'(1);
    end else if (fl_x > len_w) begin
      flen_w = len_w;
    end else begin
      flen_w = fl_x;
    end

    // write pointer steps, wrap at ring length
    wp_x  = LW'(wp_r);
    rp_x  = LW'(rp_r);
    wp1_x = (wp_x + LW'(1) >= len_w) ? '0 : wp_x + LW'(1);
    wp2_x = (wp1_x + LW'(1) >= len_w) ? '0 : wp1_x + LW'(1);
    wp1   = wp1_x[AW-1:0];
    wp2   = wp2_x[AW-1:0];

    // read command index check
    idx_x  = LW'(in_read_index);
    idx_ok = idx_x < LW'(RING_DEPTH);

    // slip down-counter
    rate_eff = in_rate_load ? in_adjust_rate : rate_r;
    cnt_base = in_rate_load ? asrf_pkg::CNT_W'(1) : cnt_r;
    neg      = rate_eff[asrf_pkg::RATE_W-1];
    rate_neg = asrf_pkg::RATE_W'(0) - rate_eff;
    if (!neg) begin
      mag = rate_eff[asrf_pkg::CNT_W-1:0];
    end else if (rate_neg[asrf_pkg::RATE_W-1]) begin
      mag = '1;
    end else begin
      mag = rate_neg[asrf_pkg::CNT_W-1:0];
    end
    cnt_dec = cnt_base - asrf_pkg::CNT_W'(1);
    slip_ev = 1'b0;
    cnt_new = cnt_base;
    if (rate_eff != '0) begin
      if (cnt_dec == '0) begin
        cnt_new = mag;
        slip_ev = 1'b1;
      end else begin
        cnt_new = cnt_dec;
      end
    end
    is_drop = slip_ev && neg;
    is_dup  = slip_ev && !neg;

    if (is_drop) begin
      slip_code = asrf_pkg::SLIP_DROP;
    end else if (is_dup) begin
      slip_code = asrf_pkg::SLIP_DUP;
    end else begin
      slip_code = asrf_pkg::SLIP_NONE;
    end

    // fill, recomputed from the pointers on a chunk start
    fill_rc   = (wp_x < rp_x) ? (len_w - rp_x + wp_x) : (wp_x - rp_x);
    fill_base = in_rate_load ? fill_rc[asrf_pkg::FILL_W-1:0] : fill_r;
    fill_st   = fill_base + (is_dup ? asrf_pkg::FILL_W'(2) : asrf_pkg::FILL_W'(1));
    frame_hit = !is_drop && (LW'(fill_st) >= flen_w);
    fill_new  = frame_hit ? fill_st - flen_w[asrf_pkg::FILL_W-1:0] : fill_st;

    // read pointer advance: no subtract or one subtract of the ring length, else the serial remainder
    sum_x    = (LW+1)'(rp_r) + (LW+1)'(flen_w);
    len_xx   = (LW+1)'(len_w);
    diff_x   = sum_x - len_xx;
    slow_mod = 1'b0;
    if (sum_x < len_xx) begin
      rp_fast = sum_x[AW-1:0];
    end else if (diff_x < len_xx) begin
      rp_fast = diff_x[AW-1:0];
    end else begin
      rp_fast  = rp_r;
      slow_mod = 1'b1;
    end
  end

  // ---------------------------------------------------------------- serial remainder step
  logic [2*LW:0] mod_sh;
  logic          mod_ge;
  logic [LW:0]   mod_rem_step;

  always_comb begin
    mod_sh       = (2*LW+1)'(mod_div_r) << mod_k_r;
    mod_ge       = (2*LW+1)'(mod_rem_r) >= mod_sh;
    mod_rem_step = mod_ge ? mod_rem_r - mod_sh[LW:0] : mod_rem_r;
  end

  // ---------------------------------------------------------------- ram
  always_comb begin
    ram_we    = dup_pend_r || (push_acc && !is_drop);
    ram_waddr = dup_pend_r ? dup_addr_r : wp_r;
    ram_wdata = dup_pend_r ? dup_data_r : in_sample;
    ram_re    = read_acc && idx_ok;
    ram_raddr = idx_x[AW-1:0];
  end

  asrf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_len_r  <= asrf_pkg::RING_LEN_RST;
      frame_len_r <= asrf_pkg::FRAME_LEN_RST;
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      rate_r      <= '0;
      cnt_r       <= '0;
      dup_pend_r  <= 1'b0;
      mod_busy_r  <= 1'b0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      // config writes, unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          asrf_pkg::REG_RING_LEN:  ring_len_r  <= cfg_data;
          asrf_pkg::REG_FRAME_LEN: frame_len_r <= cfg_data;
          default: ;
        endcase
      end

      dup_pend_r <= 1'b0;

      if (push_acc) begin
        rate_r <= rate_eff;
        cnt_r  <= cnt_new;
        if (is_drop) begin
          fill_r <= fill_base;
        end else begin
          fill_r <= fill_new;
          wp_r   <= is_dup ? wp2 : wp1;
          dup_pend_r <= is_dup;
          if (frame_hit) begin
            if (slow_mod) begin
              mod_busy_r <= 1'b1;
            end else begin
              rp_r <= rp_fast;
            end
          end
        end
      end

      // remainder finishes on its last bit
      if (mod_busy_r && (mod_k_r == '0)) begin
        mod_busy_r <= 1'b0;
        rp_r       <= mod_rem_step[AW-1:0];
      end

      // pipeline valids
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (push_acc && is_dup) begin
      dup_addr_r <= wp1;
      dup_data_r <= in_sample;
    end

    if (push_acc && !is_drop && frame_hit && slow_mod) begin
      mod_rem_r <= sum_x;
      mod_div_r <= len_w;
      mod_k_r   <= KW'(LW);
    end else if (mod_busy_r) begin
      mod_rem_r <= mod_rem_step;
      mod_k_r   <= mod_k_r - KW'(1);
    end

    if (in_acc) begin
      s1_read_r   <= (in_cmd == asrf_pkg::CMD_READ);
      s1_idx_ok_r <= idx_ok;
      if (in_cmd == asrf_pkg::CMD_READ) begin
        s1_frame_r <= 1'b0;
        s1_start_r <= '0;
        s1_slip_r  <= asrf_pkg::SLIP_NONE;
      end else begin
        s1_frame_r <= frame_hit;
        s1_start_r <= frame_hit ? rp_x[asrf_pkg::START_W-1:0] : '0;
        s1_slip_r  <= slip_code;
      end
    end

    if (s1_adv) begin
      out_frame_r <= s1_frame_r;
      out_start_r <= s1_start_r;
      out_slip_r  <= s1_slip_r;
      out_data_r  <= (s1_read_r && s1_idx_ok_r) ? ram_rdata : '0;
    end
  end

  assign out_valid       = out_v_r;
  assign out_frame_ready = out_frame_r;
  assign out_frame_start = out_start_r;
  assign out_slip        = out_slip_r;
  assign out_read_data   = out_data_r;

  // ---------------------------------------------------------------- assertions
  // the second copy of a duplicated sample owns the write port
  a_dup_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    dup_pend_r |-> in_stall)
    else $error("input taken while a duplicate write is pending");

  // a held read stage must keep its ram data
  a_hold_keeps_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |-> !ram_re)
    else $error("ram read issued while read stage is held");

  // every accepted beat lands in the read stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted beat lost before read stage");

  // read pointer stays frozen while the remainder runs
  a_mod_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_busy_r && (mod_k_r != '0)) |=> ($stable(rp_r) && mod_busy_r && in_stall))
    else $error("read pointer moved during remainder");

endmodule

`default_nettype wire

@@ dv/audio_slip_ring_framer_core_tb.sv @@
// testbench for the audio slip ring framer core: slips, full ring, backpressure, ring geometries
`timescale 1ns / 1ps

module audio_slip_ring_framer_core_tb;
  import asrf_pkg::*;

  localparam int SW           = 32;
  localparam int DEPTH        = 4096;
  localparam int DRAIN_CYCLES = 20;   // covers the bit-serial remainder after a ring shrink
  localparam int HOLD_CYCLES  = 300;
  localparam int SHOW_LIMIT   = 40;
  localparam int PHASE_BEATS  = 190;

  localparam rate_t RATE_MOST_NEG = 17'h10000;  // magnitude 65536, reload saturates
  localparam rate_t RATE_MAX      = 17'h0FFFF;

  typedef struct {
    logic              cmd;
    logic [SW-1:0]     sample;
    logic              load;
    rate_t             rate;
    logic [IDX_W-1:0]  index;
  } beat_t;

  typedef struct {
    logic               ready;
    logic [START_W-1:0] start;
    slip_t              slip;
    logic [SW-1:0]      data;
  } framer_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_PUSH;
  logic [SW-1:0]        in_sample = '0;
  logic                 in_rate_load = 1'b0;
  rate_t                in_adjust_rate = '0;
  logic [IDX_W-1:0]     in_read_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_frame_ready;
  logic [START_W-1:0]   out_frame_start;
  logic signed [SLIP_W-1:0] out_slip;
  logic [SW-1:0]        out_read_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index = REG_RING_LEN;
  cfg_data_t            cfg_data = '0;

  // predicted block state
  logic [SW-1:0]  ring_model [DEPTH];
  bit             ever_written [DEPTH];
  int unsigned    written_list [$];
  int unsigned    wr_ptr = 0;
  int unsigned    rd_ptr = 0;
  fill_t          fill_q = '0;
  rate_t          rate_q = '0;
  cnt_t           slip_cnt = '0;
  cfg_data_t      ring_len_q = RING_LEN_RST;
  cfg_data_t      frame_len_q = FRAME_LEN_RST;

  framer_result_t expected_results [$];

  int  mismatches = 0;
  int  shown = 0;
  int  beats_sent = 0;
  int  frames_seen = 0;
  int  slips_seen = 0;
  int  reads_seen = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  audio_slip_ring_framer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_sample      (in_sample),
    .in_rate_load   (in_rate_load),
    .in_adjust_rate (in_adjust_rate),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_ready(out_frame_ready),
    .out_frame_start(out_frame_start),
    .out_slip       (out_slip),
    .out_read_data  (out_read_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("FAILED: results differ");
    $display("timeout with %0d results still expected", expected_results.size());
    $finish;
  end

  // one ring write, pointer wraps at the effective ring length
  function automatic void store_sample(input logic [SW-1:0] v, input int unsigned len);
    ring_model[wr_ptr] = v;
    if (!ever_written[wr_ptr]) begin
      ever_written[wr_ptr] = 1'b1;
      written_list.push_back(wr_ptr);
    end
    wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
    fill_q = fill_q + 1'b1;
  endfunction

  function automatic framer_result_t predict_beat(input beat_t b);
    framer_result_t r;
    int unsigned    len;
    int unsigned    flen;
    logic [RATE_W-1:0] mag17;
    cnt_t           mag;
    logic           neg;
    int             dir;
    r.ready = 1'b0;
    r.start = '0;
    r.slip  = SLIP_NONE;
    r.data  = '0;
    len  = (ring_len_q == 0) ? 1 : (ring_len_q > DEPTH) ? DEPTH : ring_len_q;
    flen = (frame_len_q == 0) ? 1 : (frame_len_q > len) ? len : frame_len_q;
    if (b.cmd == CMD_READ) begin
      r.data = ring_model[b.index];
      return r;
    end
    // chunk start: new rate, counter restarts, fill taken from the pointers
    if (b.load) begin
      rate_q   = b.rate;
      slip_cnt = 1;
      fill_q   = (wr_ptr < rd_ptr) ? fill_t'(len - rd_ptr + wr_ptr) : fill_t'(wr_ptr - rd_ptr);
    end
    neg   = rate_q[RATE_W-1];
    mag17 = neg ? -rate_q : rate_q;
    mag   = (mag17 > 17'h0FFFF) ? 16'hFFFF : mag17[CNT_W-1:0];
    dir   = 0;
    if (rate_q != 0) begin
      slip_cnt = slip_cnt - 1'b1;
      if (slip_cnt == 0) begin
        slip_cnt = mag;
        dir = neg ? -1 : 1;
      end
    end
    // a dropped sample is neither stored nor framed
    if (dir < 0) begin
      r.slip = SLIP_DROP;
      return r;
    end
    if (dir > 0) begin
      r.slip = SLIP_DUP;
      store_sample(b.sample, len);
    end
    store_sample(b.sample, len);
    if (fill_q >= flen) begin
      r.ready = 1'b1;
      r.start = rd_ptr[START_W-1:0];
      rd_ptr  = (rd_ptr + flen) % len;
      fill_q  = fill_q - fill_t'(flen);
    end
    return r;
  endfunction

  function automatic rate_t pick_rate();
    int unsigned m;
    m = $urandom_range(1, 12);
    case ($urandom_range(9))
      0: return '0;
      1: return rate_t'($urandom);
      2: begin
        case ($urandom_range(2))
          0: return RATE_MOST_NEG;
          1: return RATE_MAX;
          default: return -RATE_MAX;
        endcase
      end
      default: return $urandom_range(1) ? rate_t'(m) : -rate_t'(m);
    endcase
  endfunction

  // offer one beat after a random idle gap, hold it until taken, then predict
  task automatic send_beat(input logic cmd, input logic [SW-1:0] smp, input logic load,
                           input rate_t rate, input logic [IDX_W-1:0] idx);
    beat_t          b;
    framer_result_t r;
    int             gap;
    b.cmd    = cmd;
    b.sample = smp;
    b.load   = load;
    b.rate   = rate;
    b.index  = idx;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_sample      <= smp;
    in_rate_load   <= load;
    in_adjust_rate <= rate;
    in_read_index  <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = predict_beat(b);
    expected_results.push_back(r);
    beats_sent++;
    if (r.ready) frames_seen++;
    if (r.slip != SLIP_NONE) slips_seen++;
    if (cmd == CMD_READ) reads_seen++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_RING_LEN) ring_len_q = val;
    else if (idx == REG_FRAME_LEN) frame_len_q = val;
  endtask

  task automatic set_geometry(input cfg_data_t ring, input cfg_data_t frame);
    wait_drained();
    write_reg(REG_RING_LEN, ring);
    write_reg(REG_FRAME_LEN, frame);
    cfg_valid <= 1'b0;
  endtask

  // chunks of pushes opened by a rate load, reads of written entries mixed in,
  // now and then a stray rate load with a random rate
  task automatic run_traffic(input int n);
    int               chunk_left;
    rate_t            chunk_rate;
    bit               fresh;
    int               roll;
    logic [IDX_W-1:0] idx;
    chunk_left = 0;
    chunk_rate = '0;
    fresh      = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (chunk_left == 0) begin
        chunk_left = $urandom_range(1, 48);
        chunk_rate = pick_rate();
        fresh = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 15 && written_list.size() != 0) begin
        idx = $urandom_range(DEPTH - 1);
        if (!ever_written[idx]) idx = written_list[$urandom_range(written_list.size() - 1)];
        send_beat(CMD_READ, $urandom, $urandom_range(1), rate_t'($urandom), idx);
      end else begin
        send_beat(CMD_PUSH, $urandom, fresh || roll >= 97,
                  fresh ? chunk_rate : rate_t'($urandom), $urandom);
        fresh = 1'b0;
        chunk_left--;
      end
    end
  endtask

  // result side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    framer_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (shown++ < SHOW_LIMIT)
          $display("%0t: unexpected result, expected nothing, got ready=%0b start=%0d slip=%0d data=%h",
                   $time, out_frame_ready, out_frame_start, out_slip, out_read_data);
      end else begin
        want = expected_results.pop_front();
        if (out_frame_ready !== want.ready || out_frame_start !== want.start ||
            out_slip !== want.slip || out_read_data !== want.data) begin
          mismatches++;
          if (shown++ < SHOW_LIMIT)
            $display("%0t: expected ready=%0b start=%0d slip=%0d data=%h, got ready=%0b start=%0d slip=%0d data=%h",
                     $time, want.ready, want.start, want.slip, want.data,
                     out_frame_ready, out_frame_start, out_slip, out_read_data);
        end
      end
    end
  end

  // every slip direction, both rate extremes, counter period, ignored fields on reads
  task automatic test_directed_slips();
    idle_pct  = 0;
    stall_pct = 0;
    send_beat(CMD_PUSH, 32'h0000_0000, 1'b1, '0, '0);
    send_beat(CMD_PUSH, 32'hFFFF_FFFF, 1'b0, -rate_t'(1), 12'hFFF);
    send_beat(CMD_READ, 32'hFFFF_FFFF, 1'b1, RATE_MOST_NEG, 12'd0);
    send_beat(CMD_READ, 32'h0, 1'b0, '0, 12'd1);
    send_beat(CMD_PUSH, 32'hA5A5_A5A5, 1'b1, rate_t'(1), '0);     // duplicate every push
    send_beat(CMD_PUSH, 32'h5A5A_5A5A, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'h1111_1111, 1'b1, -rate_t'(1), '0);    // drop every push
    send_beat(CMD_PUSH, 32'h2222_2222, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'h3333_3333, 1'b1, RATE_MOST_NEG, '0);  // saturated reload
    send_beat(CMD_PUSH, 32'h4444_4444, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'h5555_5555, 1'b1, RATE_MAX, '0);
    send_beat(CMD_PUSH, 32'h6666_6666, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'h7777_7777, 1'b1, rate_t'(3), '0);     // slip, then every third
    for (int i = 0; i < 3; i++) send_beat(CMD_PUSH, $urandom, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'h8888_8888, 1'b1, -rate_t'(2), '0);
    send_beat(CMD_PUSH, 32'h9999_9999, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'hAAAA_AAAA, 1'b0, '0, '0);
    send_beat(CMD_PUSH, 32'hBBBB_BBBB, 1'b1, '0, '0);
    send_beat(CMD_READ, 32'h0, 1'b0, '0, 12'd3);
    send_beat(CMD_READ, 32'h0, 1'b0, '0, 12'd9);
    wait_drained();
  endtask

  // every push duplicated so half a ring of beats writes all entries,
  // after which any read index is legal
  task automatic test_fill_whole_ring();
    idle_pct  = 0;
    stall_pct = 0;
    send_beat(CMD_PUSH, $urandom, 1'b1, rate_t'(1), '0);
    repeat (DEPTH / 2 - 1) send_beat(CMD_PUSH, $urandom, 1'b0, rate_t'($urandom), $urandom);
    send_beat(CMD_READ, $urandom, 1'b0, '0, 12'd0);
    send_beat(CMD_READ, $urandom, 1'b1, '0, 12'hFFF);
    send_beat(CMD_READ, $urandom, 1'b0, '0, 12'h800);
    send_beat(CMD_READ, $urandom, 1'b0, '0, 12'h7FF);
    repeat (16) send_beat(CMD_READ, $urandom, $urandom_range(1), rate_t'($urandom), $urandom);
    wait_drained();
  endtask

  // result side held off while the sender keeps offering, so the block fills up
  task automatic test_backpressure();
    set_geometry(13'd16, 13'd4);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    run_traffic(60);
    wait_drained();
  endtask

  // ring and frame lengths from the extremes to odd ratios, idling varied per phase
  task automatic test_geometry_sweep();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_geometry(13'd16, 13'd4);
        1: set_geometry(13'd12, 13'd5);       // ring not a multiple of the frame
        2: set_geometry(13'd1, 13'd1);
        3: set_geometry(13'd0, 13'd0);        // both act as one
        4: set_geometry(13'd8191, 13'd8191);  // clamps to the full ring
        5: set_geometry(13'd64, 13'd0);       // shrink below live pointers
        6: set_geometry(13'd40, 13'd100);     // frame longer than ring
        7: set_geometry(RING_LEN_RST, FRAME_LEN_RST);
        8: set_geometry(13'd3000, 13'd7);
        default: set_geometry($urandom_range(1, 300), $urandom_range(1, 40));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      run_traffic(PHASE_BEATS);
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_slips();
    test_fill_whole_ring();
    test_backpressure();
    test_geometry_sweep();
    wait_drained();
    $display("covered %0d beats: %0d frames ready, %0d slips, %0d reads", beats_sent,
             frames_seen, slips_seen, reads_seen);
    $display("over ring lengths 0 to 8191, frame lengths 0 to 8191, with idle and stall mixes");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/asrf_pkg.sv
design/asrf_ram.sv
design/audio_slip_ring_framer_core.sv
dv/audio_slip_ring_framer_core_tb.sv
